[rtl/button_edge_and_double_click_core_macros.svh]
// Assertion macros shared by the RTL of the button edge and double-click core
`ifndef BUTTON_EDGE_AND_DOUBLE_CLICK_CORE_MACROS_SVH
`define BUTTON_EDGE_AND_DOUBLE_CLICK_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BEDC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bedc assertion failed");

// next-cycle implication, disabled during reset
`define BEDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bedc assertion failed");

`endif

[rtl/bedc_pkg.sv]
// Shared constants and types for the button edge and double-click core
package bedc_pkg;

  localparam int NUM_BUTTONS        = 3;
  localparam int LEVEL_W            = 3;
  localparam int FIELD_TIME_W       = 32;
  localparam int FIELD_POS_W        = 16;
  localparam int INTERVAL_W         = 32;
  localparam int POSITION_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF     = 32;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd500;

  localparam int BTN_LEFT   = 0;
  localparam int BTN_RIGHT  = 1;
  localparam int BTN_MIDDLE = 2;

  typedef enum logic [1:0] {
    CODE_NONE   = 2'd0,
    CODE_LEFT   = 2'd1,
    CODE_RIGHT  = 2'd2,
    CODE_MIDDLE = 2'd3
  } press_code_t;

endpackage

[rtl/bedc_poll_if.sv]
// Poll input channel
interface bedc_poll_if
  import bedc_pkg::*;
;
  logic                           valid;
  logic                           ready;
  logic [LEVEL_W-1:0]             button_levels;
  logic [FIELD_TIME_W-1:0]        now_time;
  logic signed [FIELD_POS_W-1:0]  pointer_x;
  logic signed [FIELD_POS_W-1:0]  pointer_y;

  modport source (output valid, button_levels, now_time, pointer_x, pointer_y,
                  input ready);
  modport sink   (input valid, button_levels, now_time, pointer_x, pointer_y,
                  output ready);
endinterface

[rtl/bedc_result_if.sv]
// Result output channel
interface bedc_result_if
  import bedc_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] held_mask;
  logic [LEVEL_W-1:0] pressed_mask;
  logic [LEVEL_W-1:0] released_mask;
  logic [LEVEL_W-1:0] double_mask;
  logic [1:0]         pressed_code;

  modport source (output valid, held_mask, pressed_mask, released_mask, double_mask,
                  pressed_code, input ready);
  modport sink   (input valid, held_mask, pressed_mask, released_mask, double_mask,
                  pressed_code, output ready);
endinterface

[rtl/bedc_cfg_if.sv]
// Configuration write channel
interface bedc_cfg_if
  import bedc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [INTERVAL_W-1:0] double_click_interval;

  modport source (output valid, double_click_interval, input ready);
  modport sink   (input valid, double_click_interval, output ready);
endinterface

[rtl/button_edge_and_double_click_core.sv]
// Button edge and double-click detector, top level
// One poll per clock while the result is taken: a poll is registered on transfer,
// decoded against the previous levels and the stored press time and position of each
// button in the next cycle, and lands in the result register, so a new poll may follow
// every cycle. The limit is the single-cycle path from the poll register through the
// per-button subtract and compare into the result register; a stalled result holds
// the poll register, which in turn drops ready. Configuration writes are always taken
// and should only be made while the block is idle.
module button_edge_and_double_click_core
  import bedc_pkg::*;
#(
  parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int TIME_WIDTH     = TIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bedc_poll_if.sink     poll,
  bedc_cfg_if.sink      cfg,
  bedc_result_if.source result
);

`include "button_edge_and_double_click_core_macros.svh"

  localparam int CMP_W = (TIME_WIDTH > INTERVAL_W) ? TIME_WIDTH : INTERVAL_W;

  logic [INTERVAL_W-1:0] interval;

  logic                    s1_valid;
  logic [LEVEL_W-1:0]      s1_levels;
  logic [FIELD_TIME_W-1:0] s1_time;
  logic [FIELD_POS_W-1:0]  s1_x;
  logic [FIELD_POS_W-1:0]  s1_y;
  logic                    s1_adv;

  logic [LEVEL_W-1:0]        prev_levels;
  logic [TIME_WIDTH-1:0]     last_time [NUM_BUTTONS];
  logic [POSITION_WIDTH-1:0] last_x    [NUM_BUTTONS];
  logic [POSITION_WIDTH-1:0] last_y    [NUM_BUTTONS];

  logic [TIME_WIDTH-1:0]     now_t;
  logic [POSITION_WIDTH-1:0] px;
  logic [POSITION_WIDTH-1:0] py;
  logic [LEVEL_W-1:0]        pressed;
  logic [LEVEL_W-1:0]        released;
  logic [LEVEL_W-1:0]        dbl;
  press_code_t               code;
  logic [TIME_WIDTH-1:0]     elapsed [NUM_BUTTONS];

  logic                out_valid;
  logic [LEVEL_W-1:0]  out_held;
  logic [LEVEL_W-1:0]  out_pressed;
  logic [LEVEL_W-1:0]  out_released;
  logic [LEVEL_W-1:0]  out_double;
  press_code_t         out_code;

  assign cfg.ready  = 1'b1;
  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign poll.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RESET;
    end else if (cfg.valid) begin
      interval <= cfg.double_click_interval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll.ready) begin
      s1_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      s1_levels <= poll.button_levels;
      s1_time   <= poll.now_time;
      s1_x      <= poll.pointer_x;
      s1_y      <= poll.pointer_y;
    end
  end

  assign now_t    = TIME_WIDTH'(s1_time);
  assign px       = POSITION_WIDTH'(s1_x);
  assign py       = POSITION_WIDTH'(s1_y);
  assign pressed  = s1_levels & ~prev_levels;
  assign released = prev_levels & ~s1_levels;

  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      elapsed[b] = now_t - last_time[b];
      dbl[b] = pressed[b] && (last_time[b] != '0) &&
               (CMP_W'(elapsed[b]) < CMP_W'(interval)) &&
               (last_x[b] == px) && (last_y[b] == py);
    end
  end

  always_comb begin
    priority if (pressed[BTN_MIDDLE]) begin
      code = CODE_MIDDLE;
    end else if (pressed[BTN_RIGHT]) begin
      code = CODE_RIGHT;
    end else if (pressed[BTN_LEFT]) begin
      code = CODE_LEFT;
    end else begin
      code = CODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        last_time[b] <= '0;
        last_x[b]    <= '0;
        last_y[b]    <= '0;
      end
    end else if (s1_adv) begin
      prev_levels <= s1_levels;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (dbl[b]) begin
          last_time[b] <= '0;
        end else if (pressed[b]) begin
          last_time[b] <= now_t;
          last_x[b]    <= px;
          last_y[b]    <= py;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_held     <= s1_levels;
      out_pressed  <= pressed;
      out_released <= released;
      out_double   <= dbl;
      out_code     <= code;
    end
  end

  assign result.valid         = out_valid;
  assign result.held_mask     = out_held;
  assign result.pressed_mask  = out_pressed;
  assign result.released_mask = out_released;
  assign result.double_mask   = out_double;
  assign result.pressed_code  = out_code;

  `BEDC_ASSERT_NOW(a_double_is_press, clk, rst, out_valid, (out_double & ~out_pressed) == '0)
  `BEDC_ASSERT_NOW(a_edges_disjoint, clk, rst, out_valid, (out_pressed & out_released) == '0)
  `BEDC_ASSERT_NEXT(a_prev_tracks, clk, rst, s1_adv, prev_levels == $past(s1_levels))
  `BEDC_ASSERT_NEXT(a_adv_fills_out, clk, rst, s1_adv, out_valid)
  `BEDC_ASSERT_NEXT(a_double_clears, clk, rst, s1_adv && dbl[BTN_LEFT], last_time[BTN_LEFT] == '0)

endmodule
